// ===== hw/rtl/encoder_multiturn_velocity_tracker_macros.svh =====
// Assertion macros for the port-level checker
`ifndef ENCODER_MULTITURN_VELOCITY_TRACKER_MACROS_SVH
`define ENCODER_MULTITURN_VELOCITY_TRACKER_MACROS_SVH

// Check cons in the same cycle as ante
`define EMVT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante
`define EMVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/emvt_pkg.sv =====
// Shared types and constants for the multi-turn encoder velocity tracker
`timescale 1ns / 1ps
`default_nettype none

package emvt_pkg;

    localparam int WINDOW_DEPTH = 5;

    localparam int ANGLE_W    = 13;
    localparam int TURN_W     = 32;
    localparam int POS_W      = 45;
    localparam int DELTA_W    = 14;
    localparam int SPEED_W    = 16;
    localparam int CURRENT_W  = 16;
    localparam int TEMP_W     = 8;
    localparam int VEL_W      = 32;
    localparam int HALF_TURN  = 4096;
    localparam int FULL_TURN  = 8192;

    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int HEAD_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int WT_W   = $clog2(WINDOW_DEPTH * HALF_TURN + 1) + 2;

    localparam int SCALE_W = 15;
    localparam int NUM_W   = WT_W + SCALE_W;

    localparam int DIV_RADIX_BITS = 4;
    localparam int DIV_STEPS      = (NUM_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
    localparam int DIV_W          = DIV_STEPS * DIV_RADIX_BITS;
    localparam int DIV_CNT_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam int WOLD_W     = 17;
    localparam int WNEW_W     = 16;
    localparam int POLD_W     = VEL_W + WOLD_W;
    localparam int PNEW_W     = DIV_W + WNEW_W;
    localparam int FILT_W     = ((POLD_W > PNEW_W) ? POLD_W : PNEW_W) + 2;
    localparam int FRAC_SHIFT = 16;
    localparam int ROUND_HALF = 32768;

    localparam logic signed [DELTA_W-1:0] HALF_TURN_D = DELTA_W'(HALF_TURN);
    localparam logic signed [DELTA_W:0]   FULL_TURN_D = (DELTA_W + 1)'(FULL_TURN);
    localparam logic signed [SCALE_W-1:0] SCALE_K     = SCALE_W'(11250);
    localparam logic signed [WOLD_W-1:0]  W_OLD       = WOLD_W'(13107);
    localparam logic [WNEW_W-1:0]         W_NEW       = WNEW_W'(52429);
    localparam logic signed [VEL_W-1:0]   VEL_MAX     = {1'b0, {(VEL_W - 1){1'b1}}};
    localparam logic signed [VEL_W-1:0]   VEL_MIN     = {1'b1, {(VEL_W - 1){1'b0}}};

    typedef struct packed {
        logic [ANGLE_W-1:0]          raw_angle;
        logic signed [SPEED_W-1:0]   raw_speed;
        logic signed [CURRENT_W-1:0] raw_current;
        logic [TEMP_W-1:0]           raw_temperature;
    } frame_t;

    typedef struct packed {
        logic signed [POS_W-1:0]     total_position;
        logic signed [VEL_W-1:0]     smoothed_velocity;
        logic signed [SPEED_W-1:0]   speed_out;
        logic signed [CURRENT_W-1:0] current_out;
        logic [TEMP_W-1:0]           temperature_out;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UNWRAP,
        ST_SCALE,
        ST_ROUND,
        ST_DIVIDE,
        ST_WEIGHT,
        ST_FILTER
    } state_t;

    typedef struct packed {
        logic capture;
        logic unwrap;
        logic scale;
        logic round;
        logic div_step;
        logic weight;
        logic filter;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/emvt_ctrl.sv =====
// Sequencer for the capture, unwrap, scale, round, divide, weight and filter steps
`timescale 1ns / 1ps
`default_nettype none

module emvt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              frame_valid,
    output logic              frame_ready,
    input  emvt_pkg::status_t status,
    output emvt_pkg::cmd_t    cmd
);
    import emvt_pkg::*;

    state_t                 state_reg;
    state_t                 state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DIV_CNT_W-1:0]   cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (frame_valid)
                begin
                    state_next = ST_UNWRAP;
                end
            end
            ST_UNWRAP:
            begin
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_WEIGHT;
                end
                else
                begin
                    cnt_next = cnt_reg + DIV_CNT_W'(1);
                end
            end
            ST_WEIGHT:
            begin
                state_next = ST_FILTER;
            end
            ST_FILTER:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        frame_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                frame_ready = 1'b1;
                cmd.capture = frame_valid;
            end
            ST_UNWRAP:
            begin
                cmd.unwrap = 1'b1;
            end
            ST_SCALE:
            begin
                cmd.scale = 1'b1;
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            ST_WEIGHT:
            begin
                cmd.weight = 1'b1;
            end
            ST_FILTER:
            begin
                cmd.filter = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/emvt_datapath.sv =====
// Turn unwrap, delta window, iterative divider and velocity filter
`timescale 1ns / 1ps
`default_nettype none

module emvt_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  emvt_pkg::frame_t  frame_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data,
    output logic              result_valid,
    input  logic              result_ready,
    output emvt_pkg::result_t result_data,
    input  emvt_pkg::cmd_t    cmd,
    output emvt_pkg::status_t status
);
    import emvt_pkg::*;

    // control state
    logic                       temp_absent_reg;
    logic [ANGLE_W-1:0]         prev_angle_reg;
    logic [ANGLE_W-1:0]         prev_angle_next;
    logic [TURN_W-1:0]          turn_reg;
    logic [TURN_W-1:0]          turn_next;
    logic [FILL_W-1:0]          fill_reg;
    logic [FILL_W-1:0]          fill_next;
    logic [HEAD_W-1:0]          head_reg;
    logic [HEAD_W-1:0]          head_next;
    logic signed [WT_W-1:0]     wt_reg;
    logic signed [WT_W-1:0]     wt_next;
    logic signed [VEL_W-1:0]    vel_reg;
    logic signed [VEL_W-1:0]    vel_next;
    logic                       result_valid_reg;
    logic                       result_valid_next;

    // payload
    frame_t                     frame_reg;
    frame_t                     frame_next;
    logic signed [DELTA_W-1:0]  win_reg [WINDOW_DEPTH];
    logic signed [NUM_W-1:0]    num_reg;
    logic signed [NUM_W-1:0]    num_next;
    logic                       neg_reg;
    logic                       neg_next;
    logic [DIV_W-1:0]           quo_reg;
    logic [DIV_W-1:0]           quo_next;
    logic [FILL_W-1:0]          rem_reg;
    logic [FILL_W-1:0]          rem_next;
    logic signed [POLD_W-1:0]   pold_reg;
    logic signed [POLD_W-1:0]   pold_next;
    logic [PNEW_W-1:0]          pnew_reg;
    logic [PNEW_W-1:0]          pnew_next;
    result_t                    result_reg;
    result_t                    result_next;

    // unwrap and window
    logic signed [DELTA_W-1:0]  jump;
    logic signed [DELTA_W:0]    delta_wide;
    logic signed [DELTA_W-1:0]  delta;
    logic signed [DELTA_W-1:0]  head_entry;
    logic [FILL_W:0]            idx_sum;
    logic [HEAD_W-1:0]          wr_idx;
    logic                       win_full;

    // divider and filter
    logic [NUM_W-1:0]           mag;
    logic [DIV_W-1:0]           q_step;
    logic [FILL_W-1:0]          r_step;
    logic [FILL_W:0]            part;
    logic signed [FILT_W-1:0]   pold_s;
    logic signed [FILT_W-1:0]   pnew_s;
    logic signed [FILT_W-1:0]   pnew_adj;
    logic signed [FILT_W-1:0]   sum;
    logic signed [FILT_W-1:0]   shifted;
    logic [FILT_W-VEL_W:0]      upper;

    assign cfg_ready       = 1'b1;
    assign result_valid    = result_valid_reg;
    assign result_data     = result_reg;
    assign status.out_free = !result_valid_reg || result_ready;

    always_comb
    begin
        jump       = $signed({1'b0, frame_reg.raw_angle}) - $signed({1'b0, prev_angle_reg});
        turn_next  = turn_reg;
        delta_wide = {jump[DELTA_W-1], jump};
        if (jump > HALF_TURN_D)
        begin
            turn_next  = turn_reg - TURN_W'(1);
            delta_wide = {jump[DELTA_W-1], jump} - FULL_TURN_D;
        end
        else if (jump < -HALF_TURN_D)
        begin
            turn_next  = turn_reg + TURN_W'(1);
            delta_wide = {jump[DELTA_W-1], jump} + FULL_TURN_D;
        end
        delta = delta_wide[DELTA_W-1:0];

        win_full   = (fill_reg == FILL_W'(WINDOW_DEPTH));
        head_entry = win_reg[head_reg];
        idx_sum    = (FILL_W + 1)'(head_reg) + (FILL_W + 1)'(fill_reg);
        if (idx_sum >= (FILL_W + 1)'(WINDOW_DEPTH))
        begin
            idx_sum = idx_sum - (FILL_W + 1)'(WINDOW_DEPTH);
        end
        wr_idx = win_full ? head_reg : idx_sum[HEAD_W-1:0];
    end

    always_comb
    begin
        frame_next      = frame_reg;
        prev_angle_next = prev_angle_reg;
        fill_next       = fill_reg;
        head_next       = head_reg;
        wt_next         = wt_reg;
        pold_next       = pold_reg;
        if (cmd.capture)
        begin
            frame_next = frame_data;
        end
        if (cmd.unwrap)
        begin
            prev_angle_next = frame_reg.raw_angle;
            pold_next       = vel_reg * W_OLD;
            if (win_full)
            begin
                wt_next = wt_reg
                          - {{(WT_W - DELTA_W){head_entry[DELTA_W-1]}}, head_entry}
                          + {{(WT_W - DELTA_W){delta[DELTA_W-1]}}, delta};
                head_next = (head_reg == HEAD_W'(WINDOW_DEPTH - 1)) ?
                            '0 : head_reg + HEAD_W'(1);
            end
            else
            begin
                wt_next   = wt_reg + {{(WT_W - DELTA_W){delta[DELTA_W-1]}}, delta};
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_comb
    begin
        num_next = num_reg;
        neg_next = neg_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        mag      = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        q_step   = quo_reg;
        r_step   = rem_reg;
        part     = '0;
        for (int i = 0; i < DIV_RADIX_BITS; i++)
        begin
            part   = {r_step, q_step[DIV_W-1]};
            q_step = {q_step[DIV_W-2:0], 1'b0};
            if (part >= {1'b0, fill_reg})
            begin
                part      = part - {1'b0, fill_reg};
                q_step[0] = 1'b1;
            end
            r_step = part[FILL_W-1:0];
        end
        if (cmd.scale)
        begin
            num_next = wt_reg * SCALE_K;
        end
        if (cmd.round)
        begin
            neg_next = num_reg[NUM_W-1];
            quo_next = DIV_W'(mag + NUM_W'(fill_reg >> 1));
            rem_next = '0;
        end
        if (cmd.div_step)
        begin
            quo_next = q_step;
            rem_next = r_step;
        end
    end

    always_comb
    begin
        pnew_next = pnew_reg;
        if (cmd.weight)
        begin
            pnew_next = quo_reg * W_NEW;
        end
        pold_s   = FILT_W'(pold_reg);
        pnew_s   = $signed({{(FILT_W - PNEW_W){1'b0}}, pnew_reg});
        pnew_adj = neg_reg ? -pnew_s : pnew_s;
        sum      = pold_s + pnew_adj + FILT_W'(ROUND_HALF);
        shifted  = sum >>> FRAC_SHIFT;
        upper    = shifted[FILT_W-1:VEL_W-1];
        if ((&upper) || !(|upper))
        begin
            vel_next = shifted[VEL_W-1:0];
        end
        else if (shifted[FILT_W-1])
        begin
            vel_next = VEL_MIN;
        end
        else
        begin
            vel_next = VEL_MAX;
        end
        if (!cmd.filter)
        begin
            vel_next = vel_reg;
        end

        result_next                   = result_reg;
        result_next.total_position    = $signed({turn_reg, prev_angle_reg});
        result_next.smoothed_velocity = vel_next;
        result_next.speed_out         = frame_reg.raw_speed;
        result_next.current_out       = frame_reg.raw_current;
        result_next.temperature_out   = temp_absent_reg ? '0 : frame_reg.raw_temperature;
        if (!cmd.filter)
        begin
            result_next = result_reg;
        end

        result_valid_next = result_valid_reg;
        if (cmd.filter)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_absent_reg  <= 1'b0;
            prev_angle_reg   <= '0;
            turn_reg         <= '0;
            fill_reg         <= '0;
            head_reg         <= '0;
            wt_reg           <= '0;
            vel_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                temp_absent_reg <= cfg_data;
            end
            prev_angle_reg   <= prev_angle_next;
            if (cmd.unwrap)
            begin
                turn_reg <= turn_next;
            end
            fill_reg         <= fill_next;
            head_reg         <= head_next;
            wt_reg           <= wt_next;
            vel_reg          <= vel_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg  <= frame_next;
        num_reg    <= num_next;
        neg_reg    <= neg_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        pold_reg   <= pold_next;
        pnew_reg   <= pnew_next;
        result_reg <= result_next;
        if (cmd.unwrap)
        begin
            win_reg[wr_idx] <= delta;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/encoder_multiturn_velocity_tracker.sv =====
// Top level of the multi-turn encoder tracker with smoothed velocity
//
// Channel   Direction  Payload               Transfer
// frame     in         emvt_pkg::frame_t     frame_valid && frame_ready
// result    out        emvt_pkg::result_t    result_valid && result_ready
// cfg       in         temperature_absent    cfg_valid && cfg_ready
//
// One frame is in work at a time; its result becomes valid at the end of the filter step,
// after the unwrap, scale, round, divide and weight steps; the divider retires four quotient
// bits per cycle. frame_ready is high only while idle, so no frame is taken mid-sequence.
// A finished result waits in an output register, so the next frame is taken while it is
// stalled; the following result holds in the filter step until that register frees.
// cfg_ready is always high. Reset clears the turn count, window fill and filter state.
`timescale 1ns / 1ps
`default_nettype none

module encoder_multiturn_velocity_tracker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              frame_valid,
    output logic              frame_ready,
    input  emvt_pkg::frame_t  frame_data,
    output logic              result_valid,
    input  logic              result_ready,
    output emvt_pkg::result_t result_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);
    import emvt_pkg::*;

    cmd_t    cmd;
    status_t status;

    emvt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .status      (status),
        .cmd         (cmd)
    );

    emvt_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_data   (frame_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/emvt_checker.sv =====
// Port-level checks for the tracker, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "encoder_multiturn_velocity_tracker_macros.svh"

module emvt_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              frame_valid,
    input logic              frame_ready,
    input logic              result_valid,
    input logic              result_ready,
    input emvt_pkg::result_t result_data
);

    `EMVT_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_data), "stalled result changed")
    `EMVT_ASSERT_NEXT(a_one_in_work, frame_valid && frame_ready, !frame_ready, "frame taken while busy")
    `EMVT_ASSERT_NEXT(a_no_early_result, frame_valid && frame_ready, !$rose(result_valid), "result right after frame transfer")
    `EMVT_ASSERT_NOW(a_busy_by_transfer, $fell(frame_ready), $past(frame_valid), "busy without a frame transfer")

endmodule

bind encoder_multiturn_velocity_tracker emvt_checker u_checker (.*);

`default_nettype wire

// ===== test/emvt_frame_checker.sv =====
`timescale 1ns / 1ps
// Checker that tracks the encoder state and compares every result of the tracker
module emvt_frame_checker
    import emvt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    frame_valid,
    input  logic    frame_ready,
    input  frame_t  frame_data,
    input  logic    result_valid,
    input  logic    result_ready,
    input  result_t result_data,
    input  logic    cfg_valid,
    input  logic    cfg_ready,
    input  logic    cfg_data,
    output int      errors,
    output int      pending
);

    logic [ANGLE_W-1:0] last_angle;
    logic [TURN_W-1:0]  turns;
    logic [POS_W-1:0]   last_position;
    int                 delta_ring [WINDOW_DEPTH];
    int                 ring_fill;
    int                 ring_head;
    int                 ring_sum;
    int                 velocity;
    logic               temp_absent;
    result_t            expected_results [$];
    result_t            want;
    int                 result_count;

    function automatic result_t track_frame(frame_t f);
        result_t            r;
        int                 jump;
        logic [POS_W-1:0]   position;
        int                 delta;
        longint             num;
        longint             instant;
        longint             mix;
        longint             filtered;
        jump = int'(f.raw_angle) - int'(last_angle);
        if (jump > HALF_TURN)
            turns = turns - 1'b1;
        else if (jump < -HALF_TURN)
            turns = turns + 1'b1;
        last_angle = f.raw_angle;

        position = {turns, {ANGLE_W{1'b0}}} + POS_W'(f.raw_angle);
        delta = int'($signed(position - last_position));
        last_position = position;

        if (ring_fill >= WINDOW_DEPTH)
        begin
            ring_sum = ring_sum - delta_ring[ring_head];
            delta_ring[ring_head] = delta;
            ring_head = (ring_head + 1) % WINDOW_DEPTH;
        end
        else
        begin
            delta_ring[(ring_head + ring_fill) % WINDOW_DEPTH] = delta;
            ring_fill++;
        end
        ring_sum = ring_sum + delta;

        // round to nearest, ties away from zero
        num = longint'(ring_sum) * longint'(SCALE_K);
        if (num >= 0)
            instant = (num + ring_fill / 2) / ring_fill;
        else
            instant = -((-num + ring_fill / 2) / ring_fill);

        mix = longint'(W_OLD) * longint'(velocity) + longint'(W_NEW) * instant
            + longint'(ROUND_HALF);
        filtered = mix >>> FRAC_SHIFT;
        if (filtered > longint'(VEL_MAX))
            filtered = longint'(VEL_MAX);
        if (filtered < longint'(VEL_MIN))
            filtered = longint'(VEL_MIN);
        velocity = int'(filtered);

        r.total_position    = position;
        r.smoothed_velocity = velocity;
        r.speed_out         = f.raw_speed;
        r.current_out       = f.raw_current;
        r.temperature_out   = temp_absent ? '0 : f.raw_temperature;
        return r;
    endfunction

    task automatic compare_field(string label, logic signed [63:0] want_v,
                                 logic signed [63:0] got_v);
        if (got_v !== want_v)
        begin
            if (errors < 10)
                $display("result %0d %s: expected %0d, got %0d",
                         result_count, label, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_angle    = '0;
            turns         = '0;
            last_position = '0;
            for (int i = 0; i < WINDOW_DEPTH; i++)
                delta_ring[i] = 0;
            ring_fill     = 0;
            ring_head     = 0;
            ring_sum      = 0;
            velocity      = 0;
            temp_absent   = 1'b0;
            expected_results.delete();
            errors        = 0;
            pending       = 0;
            result_count  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                temp_absent = cfg_data;
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (errors < 10)
                        $display("result %0d: transfer with nothing expected", result_count);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("total_position", want.total_position,
                                  result_data.total_position);
                    compare_field("smoothed_velocity", want.smoothed_velocity,
                                  result_data.smoothed_velocity);
                    compare_field("speed_out", want.speed_out, result_data.speed_out);
                    compare_field("current_out", want.current_out, result_data.current_out);
                    compare_field("temperature_out", want.temperature_out,
                                  result_data.temperature_out);
                end
                result_count++;
            end
            if (frame_valid && frame_ready)
                expected_results.push_back(track_frame(frame_data));
            pending = expected_results.size();
        end
    end

endmodule

// ===== test/tb_encoder_multiturn_velocity_tracker.sv =====
`timescale 1ns / 1ps
// Testbench top: feeds encoder frames and configuration to the tracker and reports the verdict
module tb_encoder_multiturn_velocity_tracker;
    import emvt_pkg::*;

    typedef enum int {
        MOTION_CREEP,
        MOTION_CRUISE,
        MOTION_WHIP,
        MOTION_NOISE
    } motion_t;

    localparam int SETTLE_CYCLES = 4 + DIV_STEPS + 8;
    localparam int SWEEP_LEN = 20;
    localparam int SWEEP [SWEEP_LEN] = '{8191, 4095, 8191, 0, 4097, 1, 4097, 0, 4095, 8190,
                                         4093, 8188, 4091, 8186, 4091, 8188, 4093, 8190,
                                         4095, 0};
    localparam int SPEED_CORNERS [4]   = '{-32768, 32767, 0, -1};
    localparam int CURRENT_CORNERS [4] = '{32767, -32768, -1, 0};
    localparam int TEMP_CORNERS [4]    = '{255, 0, 128, 1};

    logic               clk;
    logic               rst_n;
    logic               frame_valid;
    logic               frame_ready;
    frame_t             frame_data;
    logic               result_valid;
    logic               result_ready;
    result_t            result_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_data;
    int                 errors;
    int                 pending;
    logic               steady;
    logic [ANGLE_W-1:0] shaft_angle;

    encoder_multiturn_velocity_tracker uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .frame_data   (frame_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    emvt_frame_checker frame_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .frame_data   (frame_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 13);
    endfunction

    task automatic send_frame(logic [ANGLE_W-1:0] angle, logic [SPEED_W-1:0] speed,
                              logic [CURRENT_W-1:0] current, logic [TEMP_W-1:0] temp);
        frame_t f;
        int     gap;
        f.raw_angle       = angle;
        f.raw_speed       = speed;
        f.raw_current     = current;
        f.raw_temperature = temp;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            frame_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        frame_data  <= f;
        frame_valid <= 1'b1;
        do
            @(posedge clk);
        while (!frame_ready);
    endtask

    task automatic set_temperature_absent(logic value);
        @(negedge clk);
        frame_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_motion(int count);
        motion_t kind;
        int      sent;
        int      seg_len;
        int      step;
        int      jitter;
        int      pick;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                kind = MOTION_CREEP;
            else if (pick < 7)
                kind = MOTION_CRUISE;
            else if (pick < 9)
                kind = MOTION_WHIP;
            else
                kind = MOTION_NOISE;
            seg_len = $urandom_range(4, 30);
            steady  = ($urandom_range(0, 4) == 0);
            case (kind)
                MOTION_CREEP:  step = $urandom_range(0, 60);
                MOTION_CRUISE: step = $urandom_range(61, 2500);
                MOTION_WHIP:   step = $urandom_range(3900, 4100);
                default:       step = 0;
            endcase
            if ($urandom_range(0, 1))
                step = -step;
            for (int k = 0; k < seg_len && sent < count; k++)
            begin
                if (kind == MOTION_NOISE)
                    shaft_angle = ANGLE_W'($urandom);
                else
                begin
                    jitter = $urandom_range(0, 2);
                    shaft_angle = ANGLE_W'(int'(shaft_angle) + step + jitter - 1);
                end
                send_frame(shaft_angle, SPEED_W'($urandom), CURRENT_W'($urandom),
                           TEMP_W'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap();
            @(negedge clk);
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid);
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        frame_valid  = 1'b0;
        frame_data   = '0;
        result_ready = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = 1'b0;
        steady       = 1'b0;
        shaft_angle  = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < SWEEP_LEN; i++)
            send_frame(ANGLE_W'(SWEEP[i]), SPEED_W'(SPEED_CORNERS[i % 4]),
                       CURRENT_W'(CURRENT_CORNERS[i % 4]), TEMP_W'(TEMP_CORNERS[i % 4]));
        shaft_angle = ANGLE_W'(SWEEP[SWEEP_LEN - 1]);

        set_temperature_absent(1'b1);
        run_motion(170);
        set_temperature_absent(1'b0);
        run_motion(170);
        set_temperature_absent(1'b1);
        run_motion(160);

        @(negedge clk);
        frame_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("** encoder_multiturn_velocity_tracker: PASSED **");
        else
            $display("** encoder_multiturn_velocity_tracker: FAILED **");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("** encoder_multiturn_velocity_tracker: FAILED **");
        $finish;
    end

endmodule

// ===== encoder_multiturn_velocity_tracker.f =====
+incdir+hw/rtl
hw/rtl/emvt_pkg.sv
hw/rtl/emvt_ctrl.sv
hw/rtl/emvt_datapath.sv
hw/rtl/encoder_multiturn_velocity_tracker.sv
hw/rtl/emvt_checker.sv
test/emvt_frame_checker.sv
test/tb_encoder_multiturn_velocity_tracker.sv
